>>> sv/h264ns_pkg.sv
`default_nettype none

package h264ns_pkg;

  // Widths fixed by the port fields
  localparam int FIELD_W  = 24;
  localparam int BYTE_W   = 8;
  localparam int LSIZE_W  = 3;
  localparam int BOUND_W  = 32;
  localparam int RECENT_W = 16;

  // Default offset width
  localparam int OFFSET_BITS_DEF = 24;

  // Longest length prefix; larger register values act as this
  localparam logic [LSIZE_W-1:0] MAX_PREFIX = 3'd4;

  // Start code tail byte, reset value of the two-byte history
  localparam logic [BYTE_W-1:0]   START_CODE_TAIL = 8'h01;
  localparam logic [RECENT_W-1:0] RECENT_RESET    = 16'hFFFF;
  localparam logic [BOUND_W-1:0]  BOUND_MAX       = 32'hFFFF_FFFF;

  // One input transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               first_byte;
    logic [FIELD_W-1:0] buffer_size;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic               nal_found;
    logic [FIELD_W-1:0] nal_start;
    logic [FIELD_W-1:0] nal_payload;
    logic               forbidden;
    logic [1:0]         ref_idc;
    logic [4:0]         unit_type;
    logic               buffer_done;
  } result_t;

endpackage

`default_nettype wire

>>> sv/h264_nal_unit_splitter.sv
// H.264 NAL unit splitter, one buffer byte per transaction.
//
// Input channel (in_valid/in_ready): one byte of the buffer, a flag for the
// first byte of a new buffer and the buffer size. Output channel
// (out_valid/out_ready): one transaction per NAL header byte found and one on
// the last byte of each buffer; both can share one transaction.
// cfg_wr_en/cfg_wr_data set the length prefix size (0 = start codes only);
// write it only while the block is idle.
//
// Path: an accepted byte goes into the input register, then through the
// combinational parser step into the result register, which drives
// out_valid. Throughput: one byte per cycle while the result register is not
// stalled by the receiver.
// When the receiver stalls, the result register holds and an empty input
// register takes one more byte; in_ready then drops until the result is taken.
// Reset (rst_n, synchronous) empties both registers, clears the parser state
// and sets the prefix size to 0. A byte with in_first_byte set restarts the
// offsets; bytes beyond the buffer size are consumed without effect.
`default_nettype none

module h264_nal_unit_splitter #(
  parameter int OFFSET_BITS = h264ns_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [h264ns_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic                            in_first_byte,
  input  wire logic [h264ns_pkg::FIELD_W-1:0]  in_buffer_size,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_nal_found,
  output logic [h264ns_pkg::FIELD_W-1:0]       out_nal_start,
  output logic [h264ns_pkg::FIELD_W-1:0]       out_nal_payload,
  output logic                                 out_forbidden,
  output logic [1:0]                           out_ref_idc,
  output logic [4:0]                           out_unit_type,
  output logic                                 out_buffer_done,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [h264ns_pkg::LSIZE_W-1:0]  cfg_wr_data
);
  import h264ns_pkg::*;

  logic               item_vld_r;
  item_t              item_r;
  logic               out_vld_r;
  result_t            res_r;
  result_t            res;
  logic               res_vld;
  logic               adv;
  logic [LSIZE_W-1:0] lsize_r;

  // Result register free or being emptied
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !item_vld_r || adv;

  // Prefix size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsize_r <= '0;
    end else if (cfg_wr_en) begin
      lsize_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte   <= in_data_byte;
      item_r.first_byte  <= in_first_byte;
      item_r.buffer_size <= in_buffer_size;
    end
  end

  h264ns_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (item_vld_r && adv),
    .item      (item_r),
    .lsize_cfg (lsize_r),
    .res       (res),
    .res_vld   (res_vld)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= item_vld_r && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_vld_r && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_nal_found   = res_r.nal_found;
  assign out_nal_start   = res_r.nal_start;
  assign out_nal_payload = res_r.nal_payload;
  assign out_forbidden   = res_r.forbidden;
  assign out_ref_idc     = res_r.ref_idc;
  assign out_unit_type   = res_r.unit_type;
  assign out_buffer_done = res_r.buffer_done;

endmodule

`default_nettype wire

>>> sv/h264ns_parser.sv
`default_nettype none

module h264ns_parser #(
  parameter int OFFSET_BITS = h264ns_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire h264ns_pkg::item_t               item,
  input  wire logic [h264ns_pkg::LSIZE_W-1:0]  lsize_cfg,
  output h264ns_pkg::result_t                  res,
  output logic                                 res_vld
);
  import h264ns_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int PW = OB + 1;                          // offset plus prefix size
  localparam int WW = (PW > BOUND_W) ? PW : BOUND_W;   // compare width vs boundary
  localparam int SW = WW + 1;                          // saturating sum width
  localparam int ZW = (OB > FIELD_W) ? OB : FIELD_W;   // size clamp width

  localparam logic [ZW-1:0] OFF_MASK_Z = ZW'({OB{1'b1}});
  localparam logic [PW-1:0] OFF_MASK_P = PW'({OB{1'b1}});

  // Parser state
  logic [OB-1:0]       off_r,    off_nxt;
  logic [RECENT_W-1:0] recent_r, recent_nxt;
  logic [OB-1:0]       sfrom_r,  sfrom_nxt;
  logic [BOUND_W-1:0]  nb_r,     nb_nxt;
  logic [BOUND_W-1:0]  acc_r,    acc_nxt;
  logic [LSIZE_W-1:0]  pleft_r,  pleft_nxt;
  logic                hp_r,     hp_nxt;
  logic [OB-1:0]       pstart_r, pstart_nxt;
  logic [PW-1:0]       ppay_r,   ppay_nxt;

  logic [OB-1:0]       st_off, st_sfrom, st_pstart;
  logic [RECENT_W-1:0] st_recent;
  logic [BOUND_W-1:0]  st_nb, st_acc;
  logic [LSIZE_W-1:0]  st_pleft;
  logic                st_hp;
  logic [PW-1:0]       st_ppay;

  logic [ZW-1:0]       size_z;
  logic [OB-1:0]       size;
  logic [LSIZE_W-1:0]  lsize;
  logic                in_range;
  logic [SW-1:0]       sum;
  logic [BYTE_W-1:0]   d;

  // A new buffer starts from the reset state
  always_comb begin
    if (item.first_byte) begin
      st_off    = '0;
      st_recent = RECENT_RESET;
      st_sfrom  = '0;
      st_nb     = '0;
      st_acc    = '0;
      st_pleft  = '0;
      st_hp     = 1'b0;
      st_pstart = '0;
      st_ppay   = '0;
    end else begin
      st_off    = off_r;
      st_recent = recent_r;
      st_sfrom  = sfrom_r;
      st_nb     = nb_r;
      st_acc    = acc_r;
      st_pleft  = pleft_r;
      st_hp     = hp_r;
      st_pstart = pstart_r;
      st_ppay   = ppay_r;
    end
  end

  // Clamp size to the offset range, prefix size to four
  assign size_z   = ZW'(item.buffer_size);
  assign size     = (size_z > OFF_MASK_Z) ? OB'(OFF_MASK_Z) : OB'(size_z);
  assign lsize    = (lsize_cfg > MAX_PREFIX) ? MAX_PREFIX : lsize_cfg;
  assign in_range = st_off < size;
  assign d        = item.data_byte;

  // Next state for one byte
  always_comb begin
    off_nxt    = st_off + OB'(1);
    recent_nxt = {st_recent[BYTE_W-1:0], d};
    sfrom_nxt  = st_sfrom;
    nb_nxt     = st_nb;
    acc_nxt    = st_acc;
    pleft_nxt  = st_pleft;
    hp_nxt     = 1'b0;
    pstart_nxt = st_pstart;
    ppay_nxt   = st_ppay;
    sum        = '0;

    // length prefix begins at the boundary
    if (lsize != '0 && st_pleft == '0 && BOUND_W'(st_off) == st_nb && OB <= BOUND_W) begin
      pstart_nxt = st_off;
      ppay_nxt   = PW'(st_off) + PW'(lsize);
      pleft_nxt  = lsize;
      acc_nxt    = '0;
      sfrom_nxt  = (ppay_nxt > OFF_MASK_P) ? OB'(OFF_MASK_P) : OB'(ppay_nxt);
    end else if (lsize != '0 && st_pleft == '0 && WW'(st_off) == WW'(st_nb)) begin
      pstart_nxt = st_off;
      ppay_nxt   = PW'(st_off) + PW'(lsize);
      pleft_nxt  = lsize;
      acc_nxt    = '0;
      sfrom_nxt  = (ppay_nxt > OFF_MASK_P) ? OB'(OFF_MASK_P) : OB'(ppay_nxt);
    end

    // shift in a prefix byte, close the prefix on its last byte
    if (pleft_nxt != '0) begin
      acc_nxt   = {acc_nxt[BOUND_W-BYTE_W-1:0], d};
      pleft_nxt = pleft_nxt - LSIZE_W'(1);
      if (pleft_nxt == '0) begin
        sum    = SW'(ppay_nxt) + SW'(acc_nxt);
        nb_nxt = (sum > SW'(BOUND_MAX)) ? BOUND_MAX : BOUND_W'(sum);
        if (ppay_nxt < PW'(size)) begin
          hp_nxt = 1'b1;
        end
      end
    end

    // 00 00 01 ending at this byte
    if (st_off >= OB'(2) && st_recent == '0 && d == START_CODE_TAIL) begin
      if (PW'(st_off) >= PW'(sfrom_nxt) + PW'(2) &&
          PW'(st_off) + PW'(2) < PW'(size) &&
          (lsize == '0 || WW'(st_off) + WW'(1) <= WW'(nb_nxt))) begin
        pstart_nxt = st_off - OB'(2);
        ppay_nxt   = PW'(st_off) + PW'(1);
        hp_nxt     = 1'b1;
        sfrom_nxt  = st_off + OB'(1);
      end
    end

    // bytes past the end leave the state alone
    if (!in_range) begin
      off_nxt    = st_off;
      recent_nxt = st_recent;
      sfrom_nxt  = st_sfrom;
      nb_nxt     = st_nb;
      acc_nxt    = st_acc;
      pleft_nxt  = st_pleft;
      hp_nxt     = st_hp;
      pstart_nxt = st_pstart;
      ppay_nxt   = st_ppay;
    end
  end

  // Result: pending header reported on this byte
  always_comb begin
    res.nal_found   = st_hp;
    res.nal_start   = st_hp ? FIELD_W'(st_pstart) : '0;
    res.nal_payload = st_hp ? FIELD_W'(st_ppay) : '0;
    res.forbidden   = st_hp ? d[7] : 1'b0;
    res.ref_idc     = st_hp ? d[6:5] : 2'd0;
    res.unit_type   = st_hp ? d[4:0] : 5'd0;
    res.buffer_done = (PW'(st_off) + PW'(1)) == PW'(size);
    res_vld         = in_range && (st_hp || res.buffer_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      recent_r <= RECENT_RESET;
      sfrom_r  <= '0;
      nb_r     <= '0;
      acc_r    <= '0;
      pleft_r  <= '0;
      hp_r     <= 1'b0;
      pstart_r <= '0;
      ppay_r   <= '0;
    end else if (step) begin
      off_r    <= off_nxt;
      recent_r <= recent_nxt;
      sfrom_r  <= sfrom_nxt;
      nb_r     <= nb_nxt;
      acc_r    <= acc_nxt;
      pleft_r  <= pleft_nxt;
      hp_r     <= hp_nxt;
      pstart_r <= pstart_nxt;
      ppay_r   <= ppay_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/h264ns_checker.sv
`default_nettype none

module h264ns_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_nal_found,
  input wire logic [23:0] out_nal_start,
  input wire logic [23:0] out_nal_payload,
  input wire logic        out_forbidden,
  input wire logic [1:0]  out_ref_idc,
  input wire logic [4:0]  out_unit_type,
  input wire logic        out_buffer_done
);

  // stalled result stays valid and keeps its offsets, found and done flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nal_start) &&
      $stable(out_nal_payload) && $stable(out_nal_found) && $stable(out_buffer_done))
    else $error("result changed while stalled");

  // a result without a header is a buffer end with cleared fields
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nal_found |-> out_buffer_done && out_nal_start == 24'd0 &&
      out_nal_payload == 24'd0 && !out_forbidden && out_ref_idc == 2'd0 &&
      out_unit_type == 5'd0)
    else $error("empty result carries data");

  // header lies one to four bytes after the unit start
  a_header_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nal_found |-> out_nal_payload > out_nal_start &&
      {1'b0, out_nal_payload} <= {1'b0, out_nal_start} + 25'd4)
    else $error("header offset out of reach of unit start");

  // a fresh result follows an accepted input transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input");

  // empty result side never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind h264_nal_unit_splitter h264ns_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_nal_found   (out_nal_found),
  .out_nal_start   (out_nal_start),
  .out_nal_payload (out_nal_payload),
  .out_forbidden   (out_forbidden),
  .out_ref_idc     (out_ref_idc),
  .out_unit_type   (out_unit_type),
  .out_buffer_done (out_buffer_done)
);

`default_nettype wire
